// File: rtl/core/kca_pkg.sv
package kca_pkg;

  localparam int unsigned MaxDimDefault     = 1024;
  localparam int unsigned NumClassesDefault = 16;
  localparam int unsigned FracBitsDefault   = 16;

  localparam int unsigned LenW   = 11;
  localparam int unsigned CntW   = 24;
  localparam int unsigned SumW   = 58;
  localparam int unsigned DistW  = 21;
  localparam int unsigned LabelW = 4;
  localparam int unsigned StatW  = 2;
  localparam int unsigned ClassW = 5;

  localparam logic [LenW-1:0]  LenReset = LenW'(784);
  localparam logic [CntW-1:0]  CntMax   = {CntW{1'b1}};
  localparam logic [LenW-1:0]  PosMax   = {LenW{1'b1}};
  localparam logic [SumW-1:0]  SumMax   = {SumW{1'b1}};

  localparam logic [StatW-1:0] StatOk    = 2'd0;
  localparam logic [StatW-1:0] StatLen   = 2'd1;
  localparam logic [StatW-1:0] StatEmpty = 2'd2;

  localparam logic [0:0] KindPush  = 1'b0;
  localparam logic [0:0] KindQuery = 1'b1;

  localparam int unsigned RegVectorLength = 0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input beat and read the centroid entry
    logic div_start; // start the running-mean division
    logic sqr;       // take the absolute difference and the c*n product
    logic acc;       // square the difference
    logic add;       // fold the registered square into the distance sum
    logic wr_first;  // write fx directly (first vector)
    logic wr_div;    // write the division quotient
    logic sqrt_start;
    logic finish;    // update counters and build the result
  } kca_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic in_range;   // captured position lies inside the vector
    logic is_query;
    logic is_last;
    logic empty;      // no points yet
    logic ok_len;     // last beat closes a correctly sized vector
  } kca_stat_t;

endpackage

// File: rtl/core/kca_div.sv
// Restoring serial divider, one quotient bit per cycle.
module kca_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 25
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(NumW + 1);

  logic [NumW-1:0]    quot_q, quot_d;
  logic [DenW:0]      rem_q, rem_d;
  logic [DenW-1:0]    den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DenW:0]      trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// File: rtl/core/kca_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module kca_sqrt #(
  parameter int unsigned InW = 58
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [InW-1:0]       x_i,
  output logic                 done_o,
  output logic [(InW+1)/2-1:0] root_o
);
  localparam int unsigned Steps = (InW + 1) / 2;
  localparam int unsigned XW    = 2 * Steps;
  localparam int unsigned CntBits = $clog2(Steps + 1);

  logic [XW-1:0]      x_q, x_d;
  logic [Steps+1:0]   rem_q, rem_d;
  logic [Steps-1:0]   root_q, root_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [Steps+1:0]   trial, shifted;

  always_comb begin
    x_d     = x_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[Steps-1:0], x_q[XW-1 -: 2]};
    trial   = {root_q, 2'b01};
    if (start_i) begin
      x_d    = XW'(x_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntBits'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = {x_q[XW-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = shifted - trial;
        root_d = {root_q[Steps-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[Steps-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// File: rtl/core/kca_datapath.sv
module kca_datapath #(
  parameter int unsigned MaxDim     = kca_pkg::MaxDimDefault,
  parameter int unsigned NumClasses = kca_pkg::NumClassesDefault,
  parameter int unsigned FracBits   = kca_pkg::FracBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kca_pkg::kca_cmd_t           cmd_i,
  output kca_pkg::kca_stat_t          stat_o,
  input  logic [kca_pkg::LenW-1:0]    vector_length_i,
  input  logic                        kind_i,
  input  logic [7:0]                  feature_value_i,
  input  logic [kca_pkg::LabelW-1:0]  label_i,
  input  logic                        last_i,
  output logic [kca_pkg::StatW-1:0]   status_o,
  output logic [kca_pkg::DistW-1:0]   distance_o,
  output logic signed [kca_pkg::ClassW-1:0] lead_class_o,
  output logic [kca_pkg::CntW-1:0]    lead_tally_o,
  output logic [kca_pkg::CntW-1:0]    point_count_o
);
  localparam int unsigned CW     = 8 + FracBits;
  localparam int unsigned AddrW  = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned NumW   = CW + kca_pkg::CntW;
  localparam int unsigned DenW   = kca_pkg::CntW + 1;
  localparam int unsigned RootW  = (kca_pkg::SumW + 1) / 2;
  localparam int unsigned SqW    = 2 * CW;
  localparam int unsigned LW     = kca_pkg::LabelW;

  logic [CW-1:0] mem [MaxDim];
  logic [CW-1:0] c_q;

  logic [kca_pkg::LenW-1:0]   pos_q;
  logic                        fault_q;
  logic [kca_pkg::SumW-1:0]   sum_q;
  logic [kca_pkg::CntW-1:0]   points_q;
  logic [kca_pkg::CntW-1:0]   tally_q [NumClasses];
  logic signed [kca_pkg::ClassW-1:0] lead_class_q;
  logic [kca_pkg::CntW-1:0]   lead_tally_q;

  logic                        kind_q, last_q;
  logic [7:0]                  f_q;
  logic [LW-1:0]               label_q;
  logic [kca_pkg::LenW-1:0]   cur_q;
  logic                        in_range_q;
  logic [CW-1:0]               diff_q;
  logic [SqW-1:0]              sq_q;
  logic [NumW-1:0]             prod_q;

  logic [kca_pkg::StatW-1:0]  status_q;
  logic [kca_pkg::DistW-1:0]  dist_q;

  logic [CW-1:0]   fx;
  logic            in_range_now;
  logic [AddrW-1:0] addr;
  logic            div_done, sqrt_done;
  logic [NumW-1:0] quot;
  logic [RootW-1:0] root;
  logic [kca_pkg::SumW:0] sum_add;
  logic [RootW+8-1:0] dist_wide;
  logic            ok_len;

  assign fx    = {f_q, FracBits'(0)};
  assign addr  = cur_q[AddrW-1:0];
  assign in_range_now = (pos_q < vector_length_i) &&
                        ({21'd0, pos_q} < 32'(MaxDim));
  assign ok_len = !fault_q && ((cur_q + 1'b1) == vector_length_i) &&
                  (cur_q != kca_pkg::PosMax);
  assign sum_add = {1'b0, sum_q} + (kca_pkg::SumW + 1)'(sq_q);

  always_comb begin
    if (FracBits >= 8) dist_wide = (RootW + 8)'(root) >> (FracBits - 8);
    else               dist_wide = (RootW + 8)'(root) << (8 - FracBits);
  end

  // Running-mean divider: (c*n + fx) / (n+1).
  kca_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .num_i  (prod_q + NumW'(fx)),
    .den_i  (DenW'(points_q) + DenW'(1)),
    .done_o (div_done),
    .quot_o (quot)
  );

  kca_sqrt #(.InW(kca_pkg::SumW)) u_sqrt (
    .clk_i, .rst_ni,
    .start_i(cmd_i.sqrt_start),
    .x_i    (sum_q),
    .done_o (sqrt_done),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      f_q     <= feature_value_i;
      label_q <= label_i;
      last_q  <= last_i;
      cur_q   <= pos_q;
      in_range_q <= in_range_now;
      c_q     <= mem[pos_q[AddrW-1:0]];
    end
    if (cmd_i.sqr) begin
      diff_q <= (fx > c_q) ? fx - c_q : c_q - fx;
      prod_q <= NumW'(c_q) * NumW'(points_q);
    end
    if (cmd_i.acc) sq_q <= SqW'(diff_q) * SqW'(diff_q);
    if (cmd_i.wr_first) mem[addr] <= fx;
    if (cmd_i.wr_div)   mem[addr] <= quot[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      fault_q      <= 1'b0;
      sum_q        <= '0;
      points_q     <= '0;
      for (int i = 0; i < NumClasses; i++) tally_q[i] <= '0;
      lead_class_q <= -5'sd1;
      lead_tally_q <= '0;
      status_q     <= kca_pkg::StatOk;
      dist_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        if (!in_range_now) fault_q <= 1'b1;
        if (!last_i && pos_q != kca_pkg::PosMax) pos_q <= pos_q + 1'b1;
      end
      // The square is folded in during the cycle after the acc command.
      if (cmd_i.add) begin
        sum_q <= sum_add[kca_pkg::SumW] ? kca_pkg::SumMax
                                        : sum_add[kca_pkg::SumW-1:0];
      end
      if (cmd_i.sqrt_start) dist_q <= '0;
      if (sqrt_done) begin
        dist_q <= (dist_wide > (RootW + 8)'({kca_pkg::DistW{1'b1}})) ?
                  {kca_pkg::DistW{1'b1}} : kca_pkg::DistW'(dist_wide);
      end
      if (cmd_i.finish) begin
        if (!ok_len) begin
          status_q <= kca_pkg::StatLen;
          dist_q   <= '0;
        end else if (kind_q == kca_pkg::KindPush) begin
          status_q <= kca_pkg::StatOk;
          dist_q   <= '0;
          if (points_q != kca_pkg::CntMax) points_q <= points_q + 1'b1;
          if ({{(32-LW){1'b0}}, label_q} < 32'(NumClasses)) begin
            if (tally_q[label_q] != kca_pkg::CntMax) begin
              tally_q[label_q] <= tally_q[label_q] + 1'b1;
              if (tally_q[label_q] + 1'b1 > lead_tally_q) begin
                lead_tally_q <= tally_q[label_q] + 1'b1;
                lead_class_q <= kca_pkg::ClassW'(label_q);
              end
            end
          end
        end else if (points_q == '0) begin
          status_q <= kca_pkg::StatEmpty;
          dist_q   <= '0;
        end else begin
          status_q <= kca_pkg::StatOk;
        end
        pos_q   <= '0;
        fault_q <= 1'b0;
        sum_q   <= '0;
      end
    end
  end

  assign stat_o.div_done  = div_done;
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.in_range  = in_range_q;
  assign stat_o.is_query  = kind_q;
  assign stat_o.is_last   = last_q;
  assign stat_o.empty     = (points_q == '0);
  assign stat_o.ok_len    = ok_len;

  assign status_o      = status_q;
  assign distance_o    = dist_q;
  assign lead_class_o  = lead_class_q;
  assign lead_tally_o  = lead_tally_q;
  assign point_count_o = points_q;
endmodule

// File: rtl/core/kca_ctrl.sv
module kca_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kca_pkg::kca_cmd_t   cmd_o,
  input  kca_pkg::kca_stat_t  stat_i
);
  typedef enum logic [3:0] {
    StIdle, StLoad, StSqr, StMul, StAcc, StDiv, StSqrt, StFinish, StOut
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != StIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && !out_valid_q) begin
          cmd_o.load = 1'b1;
          state_d    = StLoad;
        end
      end
      StLoad: begin
        cmd_o.sqr = 1'b1;
        state_d   = StSqr;
      end
      StSqr: begin
        if (!stat_i.in_range) begin
          state_d = stat_i.is_last ? StFinish : StIdle;
        end else if (stat_i.is_query) begin
          // An empty cluster has no centroid to measure against.
          if (stat_i.empty) begin
            state_d = stat_i.is_last ? StFinish : StIdle;
          end else begin
            cmd_o.acc = 1'b1;
            state_d   = StAcc;
          end
        end else if (stat_i.empty) begin
          cmd_o.wr_first = 1'b1;
          state_d = stat_i.is_last ? StFinish : StIdle;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end
      end
      StAcc: begin
        state_d = StMul;
      end
      StMul: begin
        state_d = stat_i.is_last ? StSqrt : StIdle;
      end
      StDiv: begin
        if (stat_i.div_done) begin
          cmd_o.wr_div = 1'b1;
          state_d = stat_i.is_last ? StFinish : StIdle;
        end
      end
      StSqrt: begin
        if (stat_i.sqrt_done) state_d = StFinish;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

// File: rtl/core/kca_acc_ctrl.sv
// Sequences the query accumulate: the square is taken on the acc command,
// folded into the sum in the following cycle, and on the last beat the
// square root starts in the cycle after the fold.
module kca_acc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kca_pkg::kca_cmd_t cmd_i,
  input  kca_pkg::kca_stat_t stat_i,
  output kca_pkg::kca_cmd_t cmd_o
);
  logic acc_q, add_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
      add_q <= 1'b0;
    end else begin
      acc_q <= cmd_i.acc;
      add_q <= acc_q;
    end
  end

  always_comb begin
    cmd_o = cmd_i;
    cmd_o.add = acc_q;
    cmd_o.sqrt_start = add_q && stat_i.is_last;
  end
endmodule

// File: rtl/core/kmeans_cluster_accumulator.sv
// K-means cluster accumulator: one element per beat. Push beats replace the
// centroid element with its running mean in 8.FRAC_BITS fixed point; a query
// vector returns the truncated Euclidean distance in 13.8 on its last beat.
// A push element runs through the 48-step serial divider once the cluster
// holds a point and skips it while the cluster is empty; a query element
// needs no divider. A last query beat also runs the 29-step serial square
// root before its result is offered. One beat is in work at a time, and a
// result waits in the output register until taken.
module kmeans_cluster_accumulator #(
  parameter int unsigned MaxDim     = kca_pkg::MaxDimDefault,
  parameter int unsigned NumClasses = kca_pkg::NumClassesDefault,
  parameter int unsigned FracBits   = kca_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  feature_value_i,
  input  logic [3:0]  label_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [20:0] distance_o,
  output logic signed [4:0] lead_class_o,
  output logic [23:0] lead_tally_o,
  output logic [23:0] point_count_o
);
  logic [kca_pkg::LenW-1:0] vlen_q;
  kca_pkg::kca_cmd_t  cmd_raw, cmd;
  kca_pkg::kca_stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'(kca_pkg::RegVectorLength * 4)) ? 32'(vlen_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= kca_pkg::LenReset;
    end else if (psel && penable && pwrite &&
                 paddr == 2'(kca_pkg::RegVectorLength * 4)) begin
      vlen_q <= pwdata[kca_pkg::LenW-1:0];
    end
  end

  kca_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o (cmd_raw),
    .stat_i(stat)
  );

  kca_acc_ctrl u_acc (
    .clk_i, .rst_ni,
    .cmd_i (cmd_raw),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  kca_datapath #(
    .MaxDim(MaxDim), .NumClasses(NumClasses), .FracBits(FracBits)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .stat_o(stat),
    .vector_length_i(vlen_q),
    .kind_i, .feature_value_i, .label_i, .last_i,
    .status_o, .distance_o, .lead_class_o, .lead_tally_o, .point_count_o
  );

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !out_valid_o) else $error("load while result pending");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr_div && cmd.wr_first)) else $error("double centroid write");
  a_out_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.finish, 2)) else $error("stray result");
endmodule
